[src/assert_macros.svh]
// Assertion shorthands shared by the RTL of the gyro/encoder fusion block.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define EGF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define EGF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define EGF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/egf_pkg.sv]
// Shared constants of the elevation gyro/encoder fusion block.
// Used by the top level; has no dependencies.
package egf_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_WEIGHT  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_CONST   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_SCALE     = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_INITIAL = 8'd3;

    // Register reset values.
    localparam logic [31:0]        SAMPLE_WEIGHT_RESET = 32'd6553600;
    localparam logic [19:0]        FILTER_CONST_RESET  = 20'd671;
    localparam logic [16:0]        GAIN_SCALE_RESET    = 17'd68203;
    localparam logic signed [31:0] OFFSET_RESET        = 32'sd31457;

    // Arithmetic constants.
    localparam logic [22:0] INC_DIVISOR    = 23'd6553600;  // 65536 * 100
    localparam logic [22:0] INC_HALF       = 23'd3276800;
    localparam logic [15:0] GYRO_NOISE     = 16'd41571;    // per-tick variance growth
    localparam logic [24:0] FS_ONE         = 25'd16777216; // 1.0 in filter units
    localparam logic [6:0]  TICKS_PER_SEC  = 7'd100;
    localparam logic [9:0]  COUNT_MAX      = 10'd1000;
    localparam logic [9:0]  MIN_SOLUTIONS  = 10'd10;
    localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

endpackage

[src/elevation_gyro_encoder_fusion_unit.sv]
// Elevation gyro/encoder fusion: top level with sequencer and state.
// Depends on egf_pkg, egf_serial_mul, egf_serial_div and assert_macros.svh.
//
// Use: one input beat per 100 Hz tick on s_* carries the gyro rate, the encoder
// angle and a reading-valid flag (tuser). Each beat yields one result beat on m_*
// with the fused angle, the averaged gyro offset and the solution variance.
// Configuration writes go through cfg_* (always ready); the user must make them while
// idle; the block does not enforce this. An offset register write also loads the running offset.
// A shared bit-serial multiplier steps through MB multiplier bits, a shared
// restoring divider through NW quotient bits (MB = max(ANGLE_WIDTH,32)+1,
// NW = VARIANCE_WIDTH+56). A tick without a reading does one multiply and one
// divide. A reading adds a check state, plus three multiplies and a divide if
// the sample weight is nonzero; past MIN_SOLUTIONS readings, the offset update
// adds two multiplies and a divide. The result turns valid as s_tready rises.
// One item is worked on at a time; s_tready is high only while the sequencer idles.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and its result waits until the receiver has taken the previous one.
// Reset (aresetn low, synchronous) restores registers and state to their
// defaults and empties the output register.
`include "assert_macros.svh"

module elevation_gyro_encoder_fusion_unit #(
    parameter int ANGLE_WIDTH    = 32,
    parameter int VARIANCE_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input beat: tdata = gyro_rate [31:0], encoder_angle [63:32]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    // tuser = reading_valid [0]
    input  logic [0:0]                    s_tuser,
    // Result beat: tdata = fused_angle [31:0], offset_estimate [63:32],
    // angle_variance [127:64]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [egf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]                   cfg_data
);
    localparam int AW  = ANGLE_WIDTH;
    localparam int VW  = VARIANCE_WIDTH;
    localparam int EW  = ((AW > 34) ? AW : 34) + 2;
    localparam int MAG = ((AW > 32) ? AW : 32) + 1;
    localparam int MA  = (VW > 57) ? VW : 57;
    localparam int MB  = MAG;
    localparam int PW  = MA + MB;
    localparam int NW  = VW + 56;
    localparam int DW  = VW + 33;

    localparam logic signed [EW-1:0] A_MAX = $signed({{(EW-AW+1){1'b0}}, {(AW-1){1'b1}}});
    localparam logic signed [EW-1:0] A_MIN = $signed({{(EW-AW+1){1'b1}}, {(AW-1){1'b0}}});
    localparam logic signed [EW-1:0] W_MAX = $signed({{(EW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [EW-1:0] W_MIN = $signed({{(EW-31){1'b1}}, {31{1'b0}}});
    localparam logic [VW-1:0] VAR_RESET = (VW >= 57) ? VW'(64'd129600 << 40) : '1;
    localparam logic [PW-1:0] HALF_Q56  = PW'(1) << 55;
    localparam logic [PW-1:0] HALF_Q24  = PW'(1) << 23;
    localparam logic [DW-1:0] ONE_Q56   = DW'(1) << 56;

    typedef enum logic [3:0] {
        S_IDLE, S_INC_MUL, S_INC_DIV, S_FUSE_MUL1, S_FUSE_DIV, S_FUSE_MUL2,
        S_FUSE_MUL3, S_OFS_CHK, S_OFS_MUL1, S_OFS_DIV, S_OFS_MUL2, S_FINISH
    } state_t;

    function automatic logic signed [AW-1:0] clip_a(input logic signed [EW-1:0] x);
        if (x > A_MAX) return AW'(A_MAX);
        else if (x < A_MIN) return AW'(A_MIN);
        else return AW'(x);
    endfunction

    function automatic logic signed [31:0] clip_w(input logic signed [EW-1:0] x);
        if (x > W_MAX) return 32'(W_MAX);
        else if (x < W_MIN) return 32'(W_MIN);
        else return 32'(x);
    endfunction

    function automatic logic [EW-1:0] mag_e(input logic signed [EW-1:0] x);
        return (x < 0) ? EW'(-x) : EW'(x);
    endfunction

    state_t                 state_reg;
    logic signed [31:0]     enc_reg, prev_reg, off_reg;
    logic                   rv_reg, neg_reg;
    logic signed [AW-1:0]   angle_reg, gi_reg;
    logic [VW-1:0]          var_reg, vn_reg;
    logic [9:0]             count_reg;
    logic [15:0]            ticks_reg;
    logic [31:0]            weight_reg;
    logic [19:0]            fc_reg;
    logic [16:0]            gain_reg;
    logic                   m_tvalid_reg;
    logic [127:0]           m_tdata_reg;
    logic                   mul_start_reg, div_start_reg;
    logic [MA-1:0]          mul_a_reg;
    logic [MB-1:0]          mul_b_reg;
    logic [NW-1:0]          div_num_reg;
    logic [DW-1:0]          div_den_reg;

    logic                   mul_done, div_done;
    logic [PW-1:0]          mul_prod;
    logic [NW-1:0]          div_quo;

    egf_serial_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a(mul_a_reg), .b(mul_b_reg), .done(mul_done), .prod(mul_prod)
    );

    egf_serial_div #(.N_W(NW), .D_W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(div_num_reg), .den(div_den_reg), .done(div_done), .quo(div_quo)
    );

    // Gyro increment and noise growth.
    logic signed [EW-1:0] angle_ext, inc, num_ofs, diff, edo_ext, off_sum;
    logic signed [AW-1:0] angle_inc, gi_inc, angle_fused;
    logic [VW:0]          var_sum;
    logic [VW-1:0]        var_noisy;
    logic [MAG-1:0]       dm;
    logic [PW-1:0]        p_round, s_round;
    logic [33:0]          step_mag;
    logic [15:0]          since;
    logic [24:0]          fs_raw, fs;
    logic signed [31:0]   est;
    logic [31:0]          rate_mag;

    // Magnitude of the incoming gyro rate.
    assign rate_mag  = s_tdata[31] ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];

    assign angle_ext = EW'(angle_reg);
    assign inc       = neg_reg ? -$signed(EW'(div_quo)) : $signed(EW'(div_quo));
    assign angle_inc = clip_a(angle_ext + inc);
    assign gi_inc    = clip_a(EW'(gi_reg) + inc);
    assign var_sum   = {1'b0, var_reg} + (VW + 1)'(egf_pkg::GYRO_NOISE);
    assign var_noisy = var_sum[VW] ? '1 : var_sum[VW-1:0];

    // Fusion correction: round(|diff| * k / 2^56), applied with the sign of diff.
    assign diff        = EW'(enc_reg) - angle_ext;
    assign p_round     = mul_prod + HALF_Q56;
    assign dm          = MAG'(p_round >> 56);
    assign angle_fused = neg_reg ? clip_a(angle_ext - $signed(EW'(dm)))
                                 : clip_a(angle_ext + $signed(EW'(dm)));

    // Offset estimate and exponential average.
    assign num_ofs  = EW'(enc_reg) - EW'(prev_reg) - EW'(gi_reg);
    assign since    = (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
    assign est      = neg_reg ? ((div_quo > NW'(33'h080000000)) ? 32'sh80000000
                                                                : -$signed(div_quo[31:0]))
                              : ((div_quo > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                               : $signed(div_quo[31:0]));
    assign edo_ext  = EW'(est) - EW'(off_reg);
    assign fs_raw   = (count_reg < egf_pkg::COUNT_MAX) ? ((25'(fc_reg) << 4) + (25'(fc_reg) << 2))
                                                       : 25'(fc_reg);
    assign fs       = (fs_raw > egf_pkg::FS_ONE) ? egf_pkg::FS_ONE : fs_raw;
    assign s_round  = mul_prod + HALF_Q24;
    assign step_mag = 34'(s_round >> 24);
    assign off_sum  = neg_reg ? EW'(off_reg) - $signed(EW'(step_mag))
                              : EW'(off_reg) + $signed(EW'(step_mag));

    // Sequencer, state registers, configuration and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            angle_reg     <= '0;
            gi_reg        <= '0;
            var_reg       <= VAR_RESET;
            off_reg       <= egf_pkg::OFFSET_RESET;
            prev_reg      <= '0;
            count_reg     <= '0;
            ticks_reg     <= '0;
            weight_reg    <= egf_pkg::SAMPLE_WEIGHT_RESET;
            fc_reg        <= egf_pkg::FILTER_CONST_RESET;
            gain_reg      <= egf_pkg::GAIN_SCALE_RESET;
            m_tvalid_reg  <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_addr)
                    egf_pkg::REG_SAMPLE_WEIGHT:  weight_reg <= cfg_data;
                    egf_pkg::REG_FILTER_CONST:   fc_reg     <= cfg_data[19:0];
                    egf_pkg::REG_GAIN_SCALE:     gain_reg   <= cfg_data[16:0];
                    egf_pkg::REG_OFFSET_INITIAL: off_reg    <= $signed(cfg_data);
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        enc_reg       <= $signed(s_tdata[63:32]);
                        rv_reg        <= s_tuser[0];
                        neg_reg       <= s_tdata[31];
                        mul_a_reg     <= MA'(rate_mag);
                        mul_b_reg     <= MB'(gain_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_INC_MUL;
                    end
                end
                S_INC_MUL: begin
                    if (mul_done) begin
                        div_num_reg   <= NW'(mul_prod) + NW'(egf_pkg::INC_HALF);
                        div_den_reg   <= DW'(egf_pkg::INC_DIVISOR);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_INC_DIV;
                    end
                end
                S_INC_DIV: begin
                    if (div_done) begin
                        angle_reg <= angle_inc;
                        gi_reg    <= gi_inc;
                        var_reg   <= var_noisy;
                        if (rv_reg && (weight_reg != 32'd0)) begin
                            mul_a_reg     <= MA'(var_noisy);
                            mul_b_reg     <= MB'(weight_reg);
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_FUSE_MUL1;
                        end else if (rv_reg) begin
                            state_reg <= S_OFS_CHK;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FUSE_MUL1: begin
                    if (mul_done) begin
                        div_num_reg   <= {var_reg, 56'd0};
                        div_den_reg   <= DW'(mul_prod) + ONE_Q56;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_FUSE_DIV;
                    end
                end
                S_FUSE_DIV: begin
                    if (div_done) begin
                        vn_reg        <= VW'(div_quo);
                        mul_a_reg     <= MA'(VW'(div_quo));
                        mul_b_reg     <= MB'(weight_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FUSE_MUL2;
                    end
                end
                S_FUSE_MUL2: begin
                    if (mul_done) begin
                        neg_reg       <= diff < 0;
                        mul_a_reg     <= MA'(mul_prod[56:0]);
                        mul_b_reg     <= MB'(mag_e(diff));
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FUSE_MUL3;
                    end
                end
                S_FUSE_MUL3: begin
                    if (mul_done) begin
                        angle_reg <= angle_fused;
                        var_reg   <= vn_reg;
                        state_reg <= S_OFS_CHK;
                    end
                end
                S_OFS_CHK: begin
                    if (count_reg > egf_pkg::MIN_SOLUTIONS) begin
                        neg_reg       <= num_ofs < 0;
                        mul_a_reg     <= MA'(mag_e(num_ofs));
                        mul_b_reg     <= MB'(egf_pkg::TICKS_PER_SEC);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_OFS_MUL1;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_OFS_MUL1: begin
                    if (mul_done) begin
                        div_num_reg   <= NW'(mul_prod) + NW'(since >> 1);
                        div_den_reg   <= DW'(since);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_OFS_DIV;
                    end
                end
                S_OFS_DIV: begin
                    if (div_done) begin
                        neg_reg       <= edo_ext < 0;
                        mul_a_reg     <= MA'(mag_e(edo_ext));
                        mul_b_reg     <= MB'(fs);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_OFS_MUL2;
                    end
                end
                S_OFS_MUL2: begin
                    if (mul_done) begin
                        off_reg   <= clip_w(off_sum);
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {64'(var_reg), off_reg, clip_w(angle_ext)};
                        if (rv_reg) begin
                            ticks_reg <= 16'd1;
                            gi_reg    <= '0;
                            prev_reg  <= enc_reg;
                            if (count_reg < egf_pkg::COUNT_MAX) begin
                                count_reg <= count_reg + 10'd1;
                            end
                        end else if (ticks_reg != egf_pkg::TICKS_MAX) begin
                            ticks_reg <= ticks_reg + 16'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // The sequencer takes no new beat while one is in progress.
    `EGF_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, !s_tready)
    // The solution counter never passes its cap.
    `EGF_ASSERT_ALWAYS(a_count_cap, count_reg <= egf_pkg::COUNT_MAX)
    // A divider result only arrives while the sequencer waits for it.
    `EGF_ASSERT_IMPLIES(a_div_owner, div_done,
        state_reg == S_INC_DIV || state_reg == S_FUSE_DIV || state_reg == S_OFS_DIV)

endmodule

[src/egf_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Stand-alone; used by the fusion top level.
module egf_serial_mul #(
    parameter int A_W = 57,
    parameter int B_W = 33
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   prod
);
    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic [P_W:0]   acc_reg;
    logic [P_W:0]   acc_next;
    logic [A_W-1:0] a_reg;
    logic [C_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [A_W:0]   sum;

    // Add the multiplicand when the low multiplier bit is set, then shift right.
    assign sum      = acc_reg[P_W:B_W] + (acc_reg[0] ? {1'b0, a_reg} : '0);
    assign acc_next = {1'b0, sum, acc_reg[B_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= {(A_W + 1)'(0), b};
                a_reg    <= a;
                cnt_reg  <= C_W'(B_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg - C_W'(1);
                if (cnt_reg == C_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[P_W-1:0];

endmodule

[src/egf_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by the fusion top level.
module egf_serial_div #(
    parameter int N_W = 120,
    parameter int D_W = 97
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo
);
    localparam int C_W = $clog2(N_W + 1);

    logic [N_W-1:0] q_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] den_reg;
    logic [C_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   trial;
    logic [D_W:0]   dif;
    logic           ge;

    // Shift in the next numerator bit and subtract when the divisor fits.
    assign trial = {rem_reg, q_reg[N_W-1]};
    assign dif   = trial - {1'b0, den_reg};
    assign ge    = !dif[D_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= C_W'(N_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? dif[D_W-1:0] : trial[D_W-1:0];
                q_reg   <= {q_reg[N_W-2:0], ge};
                cnt_reg <= cnt_reg - C_W'(1);
                if (cnt_reg == C_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
